// File: hw/rtl/language_card_bank_switch_defines.svh
// ----------------------------------------------------------------------------
// language card assertion macros
// concurrent checks sampled on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef LANGUAGE_CARD_BANK_SWITCH_DEFINES_SVH
`define LANGUAGE_CARD_BANK_SWITCH_DEFINES_SVH

// same-cycle implication
`define LCBS_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define LCBS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hw/rtl/lcbs_pkg.sv
// ----------------------------------------------------------------------------
// lcbs_pkg
// shared types and constants of the language card bank switch
// ----------------------------------------------------------------------------
`default_nettype none

package lcbs_pkg;

  localparam int ROM_BYTES_DEF = 12288;
  localparam int RAM_BYTES     = 32768;
  localparam int RAM_AW        = 15;

  localparam logic [2:0] MODE_SW_READ  = 3'd0;
  localparam logic [2:0] MODE_SW_WRITE = 3'd1;
  localparam logic [2:0] MODE_MEM_READ = 3'd2;
  localparam logic [2:0] MODE_MEM_WRITE = 3'd3;
  localparam logic [2:0] MODE_ROM_LOAD = 3'd4;

  localparam logic [15:0] WIN_START  = 16'hD000;
  localparam logic [15:0] BANK_LAST  = 16'hDFFF;
  localparam logic [15:0] HIGH_START = 16'hE000;

  localparam logic [7:0] BYTE_EMPTY = 8'hFF;

  // soft switch state
  typedef struct packed {
    logic       bank2;
    logic       read_ram;
    logic       write_en;
    logic [1:0] arm_count;
  } flags_t;

  // where the result byte comes from
  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_FF   = 2'd1,
    RD_RAM  = 2'd2,
    RD_ROM  = 2'd3
  } rd_sel_t;

endpackage

`default_nettype wire

// File: hw/rtl/lcbs_ram.sv
// ----------------------------------------------------------------------------
// lcbs_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lcbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcbs_switch.sv
// ----------------------------------------------------------------------------
// lcbs_switch
// soft switch decode: bank, read source and write enable arming
// ----------------------------------------------------------------------------
`default_nettype none

module lcbs_switch (
  input  wire  lcbs_pkg::flags_t cur,
  input  wire  logic [3:0]       nib,
  input  wire  logic             is_write,
  output lcbs_pkg::flags_t       nxt
);

  import lcbs_pkg::*;

  logic [1:0] cnt_inc;

  // saturating count of odd reads
  assign cnt_inc = (cur.arm_count >= 2'd2) ? 2'd2 : cur.arm_count + 2'd1;

  always_comb begin
    nxt          = cur;
    nxt.bank2    = ~nib[3];
    nxt.read_ram = ~(nib[1] ^ nib[0]);
    priority if (!nib[0]) begin
      nxt.arm_count = 2'd0;
      nxt.write_en  = 1'b0;
    end else if (is_write) begin
      nxt.arm_count = 2'd0;
    end else begin
      nxt.arm_count = cnt_inc;
      if (cnt_inc >= 2'd2) begin
        nxt.write_en = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/language_card_bank_switch.sv
// ----------------------------------------------------------------------------
// language_card_bank_switch
// bank-switched 32 KiB ram card with soft switches and a loadable rom image
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | in        | in_valid / in_ready   | mode, address, data_in, alt_zp
//  out     | out       | out_valid / out_ready | read_data, bank2_on,
//          |           |                       | read_ram_on, write_ram_on
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data (rom_length)
//
//  one item per cycle unless stalled; the result shows in the next cycle, the
//  byte coming from the registered read port of the card ram or rom store
//  reset starts a clearing pass over all 32768 card ram bytes, one byte a
//  cycle; in_ready stays low until it ends, cfg writes are taken throughout
//  a result that is not taken holds the output stage and drops in_ready
// ----------------------------------------------------------------------------
`default_nettype none
`include "language_card_bank_switch_defines.svh"

module language_card_bank_switch #(
  parameter int ROM_BYTES = lcbs_pkg::ROM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data_in,
  input  wire logic        alt_zp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  read_data,
  output logic             bank2_on,
  output logic             read_ram_on,
  output logic             write_ram_on,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [13:0] cfg_data
);

  import lcbs_pkg::*;

  localparam int ROM_AW = (ROM_BYTES > 1) ? $clog2(ROM_BYTES) : 1;

  logic [13:0]       rom_length;
  flags_t            flags;
  flags_t            sw_next;
  flags_t            out_flags;
  rd_sel_t           rd_sel;
  rd_sel_t           rd_sel_next;
  logic              clearing;
  logic [RAM_AW-1:0] clr_addr;
  logic              acc;
  logic              is_switch;
  logic              ram_hit;
  logic [RAM_AW-1:0] ram_idx;
  logic              rom_hit;
  logic [15:0]       rom_off;
  logic              ram_we;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic              rom_we;
  logic              rom_re;
  logic [ROM_AW-1:0] rom_addr;
  logic [7:0]        rom_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = !clearing && (!out_valid || out_ready);
  assign acc       = in_valid && in_ready;
  assign is_switch = (mode == MODE_SW_READ) || (mode == MODE_SW_WRITE);

  lcbs_switch u_switch (
    .cur      (flags),
    .nib      (address[3:0]),
    .is_write (mode == MODE_SW_WRITE),
    .nxt      (sw_next)
  );

  // ram index: side, then bank 1 / bank 2 / high 8 KiB
  always_comb begin
    ram_hit = 1'b0;
    ram_idx = {alt_zp, 1'b1, address[12:0]};
    if (address >= WIN_START && address <= BANK_LAST) begin
      ram_hit = 1'b1;
      ram_idx = {alt_zp, 1'b0, flags.bank2, address[11:0]};
    end else if (address >= HIGH_START) begin
      ram_hit = 1'b1;
    end
  end

  assign rom_off = address - WIN_START;
  assign rom_hit = (address >= WIN_START) && (rom_off < {2'b00, rom_length})
                   && (rom_off < 16'(ROM_BYTES));

  always_comb begin
    rd_sel_next = RD_ZERO;
    if (mode == MODE_MEM_READ) begin
      if (flags.read_ram) begin
        rd_sel_next = ram_hit ? RD_RAM : RD_FF;
      end else begin
        rd_sel_next = rom_hit ? RD_ROM : RD_FF;
      end
    end
  end

  // clearing pass owns the ram port after reset
  assign ram_we    = clearing || (acc && mode == MODE_MEM_WRITE && flags.write_en && ram_hit);
  assign ram_re    = acc && mode == MODE_MEM_READ && flags.read_ram && ram_hit;
  assign ram_addr  = clearing ? clr_addr : ram_idx;
  assign ram_wdata = clearing ? 8'h00 : data_in;

  assign rom_we   = acc && mode == MODE_ROM_LOAD && (address < 16'(ROM_BYTES));
  assign rom_re   = acc && mode == MODE_MEM_READ && !flags.read_ram && rom_hit;
  assign rom_addr = (mode == MODE_ROM_LOAD) ? address[ROM_AW-1:0] : rom_off[ROM_AW-1:0];

  lcbs_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_card_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  lcbs_ram #(
    .WIDTH (8),
    .DEPTH (ROM_BYTES)
  ) u_rom_store (
    .clk   (clk),
    .we    (rom_we),
    .re    (rom_re),
    .addr  (rom_addr),
    .wdata (data_in),
    .rdata (rom_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == RAM_AW'(RAM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_length <= '0;
    end else if (cfg_valid) begin
      rom_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '{bank2: 1'b1, read_ram: 1'b0, write_en: 1'b1, arm_count: 2'd0};
    end else if (acc && is_switch) begin
      flags <= sw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // result stage payload, flags as they stand after the access
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_sel    <= rd_sel_next;
      out_flags <= is_switch ? sw_next : flags;
    end
  end

  always_comb begin
    unique case (rd_sel)
      RD_ZERO: read_data = 8'h00;
      RD_FF:   read_data = BYTE_EMPTY;
      RD_RAM:  read_data = ram_rdata;
      RD_ROM:  read_data = rom_rdata;
    endcase
  end

  assign bank2_on     = out_flags.bank2;
  assign read_ram_on  = out_flags.read_ram;
  assign write_ram_on = out_flags.write_en;

  `LCBS_ASSERT_NOW(a_no_item_while_clearing, clearing, !in_ready, "item taken during ram clear")
  `LCBS_ASSERT_NEXT(a_item_gives_result, acc, out_valid, "accepted item gave no result")
  `LCBS_ASSERT_NOW(a_arm_only_on_odd_read, $rose(flags.write_en),
    $past(acc) && $past(mode) == MODE_SW_READ && $past(address[0]), "write enable armed wrongly")

endmodule

`default_nettype wire

// File: verif/language_card_bank_switch_tb.sv
// ----------------------------------------------------------------------------
// language_card_bank_switch_tb
// drives bus accesses, switch hits and rom loads into the language card and
// checks every result against a cycle-free model of the soft switches, the
// two-sided card ram and the rom image, under random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module language_card_bank_switch_tb;
  import lcbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 150000;
  localparam int WAIT_MAX       = 18;

  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  // soft switch offsets used by the directed tests
  localparam logic [3:0] SW_B2_RAM_ODD  = 4'h3;
  localparam logic [3:0] SW_B2_ROM_ODD  = 4'h1;
  localparam logic [3:0] SW_B1_RAM_ODD  = 4'hB;
  localparam logic [3:0] SW_B1_ROM_ODD  = 4'h9;
  localparam logic [3:0] SW_B1_RAM_EVEN = 4'h8;
  localparam logic [3:0] SW_B1_ROM_EVEN = 4'hA;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       bank2;
    logic       read_ram;
    logic       write_en;
  } card_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  mode = MODE_SW_READ;
  logic [15:0] address = '0;
  logic [7:0]  data_in = '0;
  logic        alt_zp = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic        bank2_on;
  logic        read_ram_on;
  logic        write_ram_on;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [13:0] cfg_data = '0;

  // card model state
  logic        sw_bank2 = 1'b1;
  logic        sw_read_ram = 1'b0;
  logic        sw_write_en = 1'b1;
  logic [1:0]  sw_arm = 2'd0;
  logic [13:0] rom_len = '0;
  bit   [7:0]  ram_image [RAM_BYTES];
  bit   [7:0]  rom_image [ROM_BYTES_DEF];
  bit          rom_loaded [ROM_BYTES_DEF];

  card_result_t expected_results[$];
  int          errors = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  language_card_bank_switch dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .address      (address),
    .data_in      (data_in),
    .alt_zp       (alt_zp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .bank2_on     (bank2_on),
    .read_ram_on  (read_ram_on),
    .write_ram_on (write_ram_on),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  // bank window maps to 0x0000 or 0x1000 of a side, $E000 up to 0x2000
  function automatic bit ram_slot(input logic [15:0] a, input logic z,
                                  output logic [14:0] idx);
    idx = '0;
    if (a >= WIN_START && a <= BANK_LAST) begin
      idx = {z, 1'b0, sw_bank2, a[11:0]};
      return 1'b1;
    end
    if (a >= HIGH_START) begin
      idx = {z, 1'b1, a[12:0]};
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic card_result_t apply_access(input logic [2:0] m, input logic [15:0] a,
                                                input logic [7:0] d, input logic z);
    card_result_t res;
    logic [14:0]  idx;
    logic [15:0]  off;
    logic [3:0]   nib;
    res = '0;
    nib = a[3:0];
    off = a - WIN_START;
    case (m)
      MODE_SW_READ, MODE_SW_WRITE: begin
        sw_bank2 = ~nib[3];
        sw_read_ram = (nib[1] == nib[0]);
        if (!nib[0]) begin
          sw_arm = 2'd0;
          sw_write_en = 1'b0;
        end else if (m == MODE_SW_WRITE) begin
          sw_arm = 2'd0;
        end else begin
          if (sw_arm < 2'd2) sw_arm = sw_arm + 2'd1;
          if (sw_arm >= 2'd2) sw_write_en = 1'b1;
        end
      end
      MODE_MEM_READ: begin
        if (sw_read_ram) begin
          res.byte_out = ram_slot(a, z, idx) ? ram_image[idx] : BYTE_EMPTY;
        end else if (a >= WIN_START && off < rom_len && off < ROM_BYTES_DEF) begin
          res.byte_out = rom_image[off];
        end else begin
          res.byte_out = BYTE_EMPTY;
        end
      end
      MODE_MEM_WRITE: begin
        if (sw_write_en && ram_slot(a, z, idx)) ram_image[idx] = d;
      end
      MODE_ROM_LOAD: begin
        if (a < ROM_BYTES_DEF) begin
          rom_image[a] = d;
          rom_loaded[a] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.bank2 = sw_bank2;
    res.read_ram = sw_read_ram;
    res.write_en = sw_write_en;
    return res;
  endfunction

  task automatic offer_access(input logic [2:0] m, input logic [15:0] a,
                              input logic [7:0] d, input logic z);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    address <= a;
    data_in <= d;
    alt_zp <= z;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(apply_access(m, a, d, z));
    items_sent++;
  endtask

  // a rom read inside the loaded length must never land on an unloaded byte
  task automatic issue_access(input logic [2:0] m, input logic [15:0] a,
                              input logic [7:0] d, input logic z);
    logic [15:0] off;
    off = a - WIN_START;
    if (m == MODE_MEM_READ && !sw_read_ram && a >= WIN_START && off < rom_len &&
        off < ROM_BYTES_DEF && !rom_loaded[off])
      offer_access(MODE_ROM_LOAD, off, 8'($urandom), 1'($urandom));
    offer_access(m, a, d, z);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_rom_length(input logic [13:0] len);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    rom_len = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // clustered around the window edges so reads hit earlier writes
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 9))
      0, 1, 2: return WIN_START + 16'($urandom_range(0, 31));
      3, 4:    return 16'hDFF0 + 16'($urandom_range(0, 31));
      5, 6:    return 16'hFFE0 + 16'($urandom_range(0, 31));
      7:       return 16'hF000 + 16'($urandom_range(0, 31));
      8:       return 16'hCFF0 + 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_rom_window();
    issue_access(MODE_ROM_LOAD, 16'h0000, 8'hA5, 1'b0);
    issue_access(MODE_ROM_LOAD, 16'(ROM_BYTES_DEF - 1), 8'h5A, 1'b1);
    issue_access(MODE_ROM_LOAD, 16'hFFFF, 8'h00, 1'b0);
    issue_access(MODE_MEM_READ, WIN_START, 8'h00, 1'b0);
    issue_access(MODE_MEM_READ, 16'hFFFF, 8'hFF, 1'b1);
    issue_access(MODE_MEM_READ, WIN_START - 16'd1, 8'h00, 1'b0);
  endtask

  task automatic test_ram_sides();
    issue_access(MODE_MEM_WRITE, WIN_START, 8'hFF, 1'b0);
    // upper address bits must not matter for a switch
    issue_access(MODE_SW_READ, {12'hFFF, SW_B2_RAM_ODD}, 8'h00, 1'b0);
    issue_access(MODE_MEM_READ, WIN_START, 8'h00, 1'b0);
    issue_access(MODE_MEM_READ, WIN_START, 8'h00, 1'b1);
    issue_access(MODE_SW_READ, {12'h000, SW_B1_RAM_ODD}, 8'h00, 1'b0);
    issue_access(MODE_MEM_WRITE, WIN_START, 8'h11, 1'b1);
    issue_access(MODE_MEM_READ, WIN_START, 8'h00, 1'b1);
    issue_access(MODE_MEM_READ, BANK_LAST, 8'h00, 1'b0);
  endtask

  task automatic test_write_arming();
    issue_access(MODE_SW_WRITE, {12'h000, SW_B1_ROM_ODD}, 8'h00, 1'b0);
    issue_access(MODE_SW_READ, {12'h000, SW_B1_RAM_EVEN}, 8'h00, 1'b0);
    issue_access(MODE_MEM_WRITE, HIGH_START, 8'h77, 1'b0);
    issue_access(MODE_MEM_READ, HIGH_START, 8'h00, 1'b0);
    issue_access(MODE_SW_READ, {12'h000, SW_B2_ROM_ODD}, 8'h00, 1'b0);
    // odd write restarts the count without touching the enable
    issue_access(MODE_SW_WRITE, {12'h000, SW_B2_RAM_ODD}, 8'h00, 1'b0);
    issue_access(MODE_SW_READ, {12'h000, SW_B2_RAM_ODD}, 8'h00, 1'b0);
    issue_access(MODE_SW_READ, {12'h000, SW_B1_RAM_ODD}, 8'h00, 1'b0);
    issue_access(MODE_SW_READ, {12'h000, SW_B2_ROM_ODD}, 8'h00, 1'b0);
    issue_access(MODE_MEM_WRITE, 16'hBFFF, 8'h33, 1'b0);
    issue_access(MODE_MEM_READ, 16'hBFFF, 8'h00, 1'b0);
  endtask

  task automatic test_spare_modes();
    issue_access(MODE_RSVD5, 16'($urandom), 8'($urandom), 1'($urandom));
    issue_access(MODE_RSVD6, 16'($urandom), 8'($urandom), 1'($urandom));
    issue_access(MODE_RSVD7, 16'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic test_rom_length();
    drain_results();
    write_rom_length(14'd1);
    issue_access(MODE_SW_WRITE, {12'h000, SW_B1_ROM_EVEN}, 8'h00, 1'b0);
    issue_access(MODE_MEM_READ, WIN_START, 8'h00, 1'b0);
    issue_access(MODE_MEM_READ, WIN_START + 16'd1, 8'h00, 1'b0);
    issue_access(MODE_MEM_READ, 16'hFFFF, 8'h00, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [13:0] lengths [5];
    logic [15:0] a;
    logic        z;
    int          phase_end;
    lengths[0] = 14'(ROM_BYTES_DEF);
    lengths[1] = 14'd0;
    lengths[2] = 14'($urandom_range(2, ROM_BYTES_DEF - 1));
    lengths[3] = 14'd1;
    lengths[4] = 14'($urandom_range(2, ROM_BYTES_DEF - 1));
    for (int p = 0; p < 5; p++) begin
      drain_results();
      write_rom_length(lengths[p]);
      phase_end = items_sent + 205;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 39) == 0) calm = ($urandom_range(0, 2) == 0);
        a = pick_address();
        z = 1'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2: issue_access(MODE_MEM_WRITE, a, 8'($urandom), z);
          3, 4, 5: issue_access(MODE_MEM_READ, a, 8'($urandom), z);
          6: begin
            // arm, write, read back
            issue_access(MODE_SW_READ, 16'($urandom) | 16'h0001, 8'($urandom), z);
            issue_access(MODE_SW_READ, 16'($urandom) | 16'h0001, 8'($urandom), z);
            issue_access(MODE_MEM_WRITE, a, 8'($urandom), z);
            issue_access(MODE_MEM_READ, a, 8'($urandom), z);
          end
          7: issue_access($urandom_range(0, 1) ? MODE_SW_WRITE : MODE_SW_READ,
                          16'($urandom), 8'($urandom), z);
          8: issue_access(MODE_ROM_LOAD, (a >= WIN_START) ? a - WIN_START : a,
                          8'($urandom), z);
          default: issue_access(3'($urandom), 16'($urandom), 8'($urandom), z);
        endcase
      end
    end
    calm = 1'b0;
  endtask

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    card_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item expected none actual %0h/%b%b%b", $time,
                 read_data, bank2_on, read_ram_on, write_ram_on);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("read_data", want.byte_out, read_data);
        check_field("bank2_on", 8'(want.bank2), 8'(bank2_on));
        check_field("read_ram_on", 8'(want.read_ram), 8'(read_ram_on));
        check_field("write_ram_on", 8'(want.write_en), 8'(write_ram_on));
      end
    end
  end

  // result side stalls independently of the input side
  always begin
    int stall;
    stall = draw_wait();
    @(negedge clk);
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!out_valid);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("language_card_bank_switch_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    // taken while the card ram is still being cleared
    write_rom_length(14'(ROM_BYTES_DEF));
    test_rom_window();
    test_ram_sides();
    test_write_arming();
    test_spare_modes();
    test_rom_length();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("language_card_bank_switch_tb passed");
    else
      $display("language_card_bank_switch_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
